[src/gray4_framebuffer_glyph_renderer_macros.svh]
// ----------------------------------------------------------------------------
// gray4 framebuffer glyph renderer assertion macros
// concurrent check helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef GRAY4_FRAMEBUFFER_GLYPH_RENDERER_MACROS_SVH
`define GRAY4_FRAMEBUFFER_GLYPH_RENDERER_MACROS_SVH

`ifndef SYNTH

`define GFB_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`define GFB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define GFB_ASSERT_NEVER(lbl, expr, msg)

`define GFB_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

[src/gfb_pkg.sv]
// ----------------------------------------------------------------------------
// gfb_pkg
// shared types, constants and glyph rom for the gray4 framebuffer renderer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gfb_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 128;
  localparam int GLYPH_COLS        = 5;
  localparam int GLYPH_ROWS        = 7;
  localparam int MAX_ROW_OUT       = 64;

  localparam logic [7:0] NIB_LO_MASK = 8'h0F;
  localparam logic [7:0] NIB_HI_MASK = 8'hF0;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_PIXEL    = 2'd1,
    OP_GLYPH    = 2'd2,
    OP_READ_ROW = 2'd3
  } gfb_op_t;

  typedef struct packed {
    logic load;
    logic fill_wr;
    logic fill_zero;
    logic pix_rd;
    logic pix_wr;
    logic adv_pix;
    logic adv_row;
    logic row_rd;
  } gfb_cmd_t;

  typedef struct packed {
    logic row_ok;
    logic glyph_ok;
    logic sweep_last;
    logic row_last_byte;
    logic bit_set;
    logic on_screen;
    logic pix_end;
    logic row_end;
  } gfb_sts_t;

  function automatic logic [7:0] glyph_column(input logic [6:0] code, input logic [2:0] col);
    logic [39:0] g;
    logic [7:0]  c;
    unique case (code)
      7'h61:   g = {8'h20, 8'h54, 8'h54, 8'h54, 8'h78};
      7'h62:   g = {8'h7F, 8'h48, 8'h44, 8'h44, 8'h38};
      7'h63:   g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h20};
      7'h64:   g = {8'h38, 8'h44, 8'h44, 8'h48, 8'h7F};
      7'h65:   g = {8'h38, 8'h54, 8'h54, 8'h54, 8'h18};
      7'h66:   g = {8'h08, 8'h7E, 8'h09, 8'h01, 8'h02};
      7'h67:   g = {8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E};
      7'h68:   g = {8'h7F, 8'h08, 8'h04, 8'h04, 8'h78};
      7'h69:   g = {8'h00, 8'h44, 8'h7D, 8'h40, 8'h00};
      7'h6A:   g = {8'h20, 8'h40, 8'h44, 8'h3D, 8'h00};
      7'h6B:   g = {8'h7F, 8'h10, 8'h28, 8'h44, 8'h00};
      7'h6C:   g = {8'h00, 8'h41, 8'h7F, 8'h40, 8'h00};
      7'h6D:   g = {8'h7C, 8'h04, 8'h18, 8'h04, 8'h78};
      7'h6E:   g = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h78};
      7'h6F:   g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
      7'h70:   g = {8'h7C, 8'h14, 8'h14, 8'h14, 8'h08};
      7'h71:   g = {8'h08, 8'h14, 8'h14, 8'h18, 8'h7C};
      7'h72:   g = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h08};
      7'h73:   g = {8'h48, 8'h54, 8'h54, 8'h54, 8'h20};
      7'h74:   g = {8'h04, 8'h3F, 8'h44, 8'h40, 8'h20};
      7'h75:   g = {8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C};
      7'h76:   g = {8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C};
      7'h77:   g = {8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C};
      7'h78:   g = {8'h44, 8'h28, 8'h10, 8'h28, 8'h44};
      7'h79:   g = {8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C};
      7'h7A:   g = {8'h44, 8'h64, 8'h54, 8'h4C, 8'h44};
      7'h30:   g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      7'h31:   g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      7'h32:   g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      7'h33:   g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      7'h34:   g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      7'h35:   g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      7'h36:   g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      7'h37:   g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      7'h38:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      7'h39:   g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      7'h3A:   g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      7'h2E:   g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      7'h21:   g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
      7'h2D:   g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      7'h3E:   g = {8'h00, 8'h41, 8'h22, 8'h14, 8'h08};
      default: g = '0;
    endcase
    unique case (col)
      3'd0:    c = g[39:32];
      3'd1:    c = g[31:24];
      3'd2:    c = g[23:16];
      3'd3:    c = g[15:8];
      3'd4:    c = g[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[src/gray4_framebuffer_glyph_renderer.sv]
// ----------------------------------------------------------------------------
// gray4_framebuffer_glyph_renderer
// 4-bit gray frame store, two pixels a byte, with a 5x7 glyph renderer
// ----------------------------------------------------------------------------
// Usage: drive in_* and raise start; a command is taken at a clock edge with
// start high and busy low. Ops: clear, draw pixel, draw glyph, read row.
// Only read row returns words: one packed byte per cycle on out_pixel_pair,
// marked by out_valid for exactly one cycle, out_last_byte on the final one.
// The receiver cannot stall; words are always taken as they appear.
// Work done while busy is high (one write and one read port):
//   clear      ROW_BYTES*SCREEN_HEIGHT bytes, one byte written per cycle
//   pixel      on screen: read, then write back the merged byte; off it: none
//   glyph      none for codes of 128 and up or a zero scale; otherwise each
//              clear font bit of the 35 is stepped over, and each set bit
//              covers scale*scale pixels, merged on screen and skipped off it
//   read row   none for a row off the screen; otherwise min(ROW_BYTES,64)
//              words, one word per cycle, each registered in rd_data_r with
//              out_valid_r before it reaches the ports
// Reset: synchronous rst_n; afterwards the store is zeroed by a clearing
// pass over all ROW_BYTES*SCREEN_HEIGHT bytes (8192 by default) with busy high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gray4_framebuffer_glyph_renderer_macros.svh"

module gray4_framebuffer_glyph_renderer #(
  parameter int SCREEN_WIDTH  = gfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = gfb_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_op,
  input  logic [7:0] in_x_coord,
  input  logic [7:0] in_y_coord,
  input  logic [3:0] in_shade,
  input  logic [7:0] in_char_code,
  input  logic [3:0] in_scale,
  output logic       out_valid,
  output logic [7:0] out_pixel_pair,
  output logic       out_last_byte
);
  import gfb_pkg::*;

  gfb_cmd_t cmd;
  gfb_sts_t sts;

  gfb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  gfb_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_shade       (in_shade),
    .in_char_code   (in_char_code),
    .in_scale       (in_scale),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_pixel_pair (out_pixel_pair),
    .out_last_byte  (out_last_byte)
  );

  `GFB_ASSERT_IMPL(a_word_follows_read, out_valid, $past(cmd.row_rd), "word without row read")
  `GFB_ASSERT_IMPL(a_wr_after_rd, cmd.pix_wr, $past(cmd.pix_rd), "pixel write without read")
  `GFB_ASSERT_NEVER(a_wr_collision, cmd.pix_wr && cmd.fill_wr, "fill and pixel write together")
  `GFB_ASSERT_IMPL(a_last_is_word, out_last_byte, out_valid, "last byte without strobe")

endmodule

[src/gfb_ctrl.sv]
// ----------------------------------------------------------------------------
// gfb_ctrl
// sequencer for reset clear, fill, pixel rmw, glyph walk and row streaming
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        op,
  input  gfb_pkg::gfb_sts_t sts,
  output gfb_pkg::gfb_cmd_t cmd,
  output logic              busy
);
  import gfb_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_FILL,
    S_PRD,
    S_PWR,
    S_GLYPH,
    S_GWR,
    S_ROW
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        cmd.fill_wr   = 1'b1;
        cmd.fill_zero = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (gfb_op_t'(op))
            OP_CLEAR:    state_nxt = S_FILL;
            OP_PIXEL:    state_nxt = S_PRD;
            OP_GLYPH:    state_nxt = sts.glyph_ok ? S_GLYPH : S_IDLE;
            OP_READ_ROW: state_nxt = sts.row_ok ? S_ROW : S_IDLE;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_PRD: begin
        if (sts.on_screen) begin
          cmd.pix_rd = 1'b1;
          state_nxt  = S_PWR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PWR: begin
        cmd.pix_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_GLYPH: begin
        priority if (!sts.bit_set) begin
          cmd.adv_row = 1'b1;
          if (sts.row_end) state_nxt = S_IDLE;
        end else if (sts.on_screen) begin
          cmd.pix_rd = 1'b1;
          state_nxt  = S_GWR;
        end else begin
          cmd.adv_pix = 1'b1;
          if (sts.pix_end) state_nxt = S_IDLE;
        end
      end
      S_GWR: begin
        cmd.pix_wr  = 1'b1;
        cmd.adv_pix = 1'b1;
        state_nxt   = sts.pix_end ? S_IDLE : S_GLYPH;
      end
      S_ROW: begin
        cmd.row_rd = 1'b1;
        if (sts.row_last_byte) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[src/gfb_datapath.sv]
// ----------------------------------------------------------------------------
// gfb_datapath
// frame store, address generation, glyph counters and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfb_datapath #(
  parameter int SCREEN_WIDTH  = gfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = gfb_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_x_coord,
  input  logic [7:0]        in_y_coord,
  input  logic [3:0]        in_shade,
  input  logic [7:0]        in_char_code,
  input  logic [3:0]        in_scale,
  input  gfb_pkg::gfb_cmd_t cmd,
  output gfb_pkg::gfb_sts_t sts,
  output logic              out_valid,
  output logic [7:0]        out_pixel_pair,
  output logic              out_last_byte
);
  import gfb_pkg::*;

  localparam int ROW_BYTES   = (SCREEN_WIDTH + 1) / 2;
  localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int ROW_OUT     = (ROW_BYTES < MAX_ROW_OUT) ? ROW_BYTES : MAX_ROW_OUT;
  localparam int PROD_W      = 17;

  logic [7:0] mem [STORE_BYTES];

  logic [7:0]        y_r;
  logic [3:0]        shade_r;
  logic [6:0]        code_r;
  logic [3:0]        scale_r;
  logic [7:0]        colx_r;
  logic [7:0]        rowy_r;
  logic [2:0]        col_r;
  logic [2:0]        row_r;
  logic [3:0]        dx_r;
  logic [3:0]        dy_r;
  logic [ADDR_W-1:0] cnt_r;
  logic [ADDR_W-1:0] row_base_r;
  logic [7:0]        rd_data_r;
  logic              out_valid_r;
  logic              out_last_r;

  logic [7:0]        px;
  logic [7:0]        py;
  logic [PROD_W-1:0] pix_addr_full;
  logic [PROD_W-1:0] row_base_full;
  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [7:0]        merged;
  logic [7:0]        glyph_bits;
  logic              wr_en;
  logic              rd_en;
  logic              dx_last;
  logic              dy_last;
  logic              row_last;
  logic              col_last;
  logic              do_row;

  // current target pixel, wraps at 8 bits
  assign px = colx_r + {4'b0000, dx_r};
  assign py = rowy_r + {4'b0000, dy_r};

  assign pix_addr_full = PROD_W'(py) * PROD_W'(ROW_BYTES) + PROD_W'(px[7:1]);
  assign pix_addr      = pix_addr_full[ADDR_W-1:0];
  assign row_base_full = PROD_W'(in_y_coord) * PROD_W'(ROW_BYTES);

  assign glyph_bits = glyph_column(code_r, col_r);

  assign dx_last  = (dx_r == (scale_r - 4'd1));
  assign dy_last  = (dy_r == (scale_r - 4'd1));
  assign row_last = (row_r == 3'(GLYPH_ROWS - 1));
  assign col_last = (col_r == 3'(GLYPH_COLS - 1));
  assign do_row   = cmd.adv_row | (cmd.adv_pix & dy_last & dx_last);

  assign sts.row_ok        = ({1'b0, in_y_coord} < 9'(SCREEN_HEIGHT));
  assign sts.glyph_ok      = !in_char_code[7] && (in_scale != 4'd0);
  assign sts.sweep_last    = (cnt_r == ADDR_W'(STORE_BYTES - 1));
  assign sts.row_last_byte = (cnt_r == ADDR_W'(ROW_OUT - 1));
  assign sts.bit_set       = glyph_bits[row_r];
  assign sts.on_screen     = ({1'b0, px} < 9'(SCREEN_WIDTH)) &&
                             ({1'b0, py} < 9'(SCREEN_HEIGHT));
  assign sts.pix_end       = dy_last && dx_last && row_last && col_last;
  assign sts.row_end       = row_last && col_last;

  // nibble merge for read-modify-write
  assign merged = px[0] ? ((rd_data_r & NIB_HI_MASK) | {4'b0000, shade_r})
                        : ((rd_data_r & NIB_LO_MASK) | {shade_r, 4'b0000});

  assign wr_en   = cmd.fill_wr | cmd.pix_wr;
  assign wr_addr = cmd.fill_wr ? cnt_r : pix_addr;
  assign wr_data = cmd.fill_wr ? (cmd.fill_zero ? 8'h00 : {shade_r, shade_r}) : merged;
  assign rd_en   = cmd.pix_rd | cmd.row_rd;
  assign rd_addr = cmd.row_rd ? (row_base_r + cnt_r) : pix_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.row_rd;
      out_last_r  <= cmd.row_rd & sts.row_last_byte;
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.fill_wr || cmd.row_rd) begin
        cnt_r <= cnt_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y_r        <= in_y_coord;
      shade_r    <= in_shade;
      code_r     <= in_char_code[6:0];
      scale_r    <= in_scale;
      colx_r     <= in_x_coord;
      rowy_r     <= in_y_coord;
      col_r      <= '0;
      row_r      <= '0;
      dx_r       <= '0;
      dy_r       <= '0;
      row_base_r <= row_base_full[ADDR_W-1:0];
    end else begin
      if (cmd.adv_pix) begin
        if (dy_last) begin
          dy_r <= '0;
          if (dx_last) begin
            dx_r <= '0;
          end else begin
            dx_r <= dx_r + 4'd1;
          end
        end else begin
          dy_r <= dy_r + 4'd1;
        end
      end
      if (do_row) begin
        if (row_last) begin
          row_r  <= '0;
          rowy_r <= y_r;
          col_r  <= col_r + 3'd1;
          colx_r <= colx_r + {4'b0000, scale_r};
        end else begin
          row_r  <= row_r + 3'd1;
          rowy_r <= rowy_r + {4'b0000, scale_r};
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_pair = rd_data_r;
  assign out_last_byte  = out_last_r;

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: gray4_framebuffer_glyph_renderer testbench
// The bench drives clear, pixel, glyph and row read commands through the
// start/busy handshake. It keeps its own copy of the packed 4-bit frame store
// and of the 5x7 font, and predicts every row read word when its command is
// taken. A checker compares each word the block streams, field by field,
// with the oldest prediction. Directed cases come first, then random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import gfb_pkg::*;

  localparam int SCR_W        = DEF_SCREEN_WIDTH;
  localparam int SCR_H        = DEF_SCREEN_HEIGHT;
  localparam int ROW_BYTES    = (SCR_W + 1) / 2;
  localparam int STORE_BYTES  = ROW_BYTES * SCR_H;
  localparam int ROW_WORDS    = (ROW_BYTES > MAX_ROW_OUT) ? MAX_ROW_OUT : ROW_BYTES;
  localparam int RANDOM_WORDS = 250;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [7:0] pair;
    logic       last;
  } row_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_op = OP_CLEAR;
  logic [7:0] in_x_coord = '0;
  logic [7:0] in_y_coord = '0;
  logic [3:0] in_shade = '0;
  logic [7:0] in_char_code = '0;
  logic [3:0] in_scale = '0;
  logic       out_valid;
  logic [7:0] out_pixel_pair;
  logic       out_last_byte;

  logic [7:0] frame_copy [STORE_BYTES];
  row_word_t  pending_words [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  logic [7:0] last_row = '0;
  string      glyph_set = "abcdefghijklmnopqrstuvwxyz0123456789:.!- >";

  gray4_framebuffer_glyph_renderer #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_shade      (in_shade),
    .in_char_code  (in_char_code),
    .in_scale      (in_scale),
    .out_valid     (out_valid),
    .out_pixel_pair(out_pixel_pair),
    .out_last_byte (out_last_byte)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** gray4_framebuffer_glyph_renderer: FAILED **");
      $finish;
    end
  end

  function automatic void flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  // font columns, column 0 in the top byte, bit 0 is the glyph's top row
  function automatic logic [39:0] font_bits(input logic [7:0] code);
    case (code)
      "a":     return {8'h20, 8'h54, 8'h54, 8'h54, 8'h78};
      "b":     return {8'h7F, 8'h48, 8'h44, 8'h44, 8'h38};
      "c":     return {8'h38, 8'h44, 8'h44, 8'h44, 8'h20};
      "d":     return {8'h38, 8'h44, 8'h44, 8'h48, 8'h7F};
      "e":     return {8'h38, 8'h54, 8'h54, 8'h54, 8'h18};
      "f":     return {8'h08, 8'h7E, 8'h09, 8'h01, 8'h02};
      "g":     return {8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E};
      "h":     return {8'h7F, 8'h08, 8'h04, 8'h04, 8'h78};
      "i":     return {8'h00, 8'h44, 8'h7D, 8'h40, 8'h00};
      "j":     return {8'h20, 8'h40, 8'h44, 8'h3D, 8'h00};
      "k":     return {8'h7F, 8'h10, 8'h28, 8'h44, 8'h00};
      "l":     return {8'h00, 8'h41, 8'h7F, 8'h40, 8'h00};
      "m":     return {8'h7C, 8'h04, 8'h18, 8'h04, 8'h78};
      "n":     return {8'h7C, 8'h08, 8'h04, 8'h04, 8'h78};
      "o":     return {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
      "p":     return {8'h7C, 8'h14, 8'h14, 8'h14, 8'h08};
      "q":     return {8'h08, 8'h14, 8'h14, 8'h18, 8'h7C};
      "r":     return {8'h7C, 8'h08, 8'h04, 8'h04, 8'h08};
      "s":     return {8'h48, 8'h54, 8'h54, 8'h54, 8'h20};
      "t":     return {8'h04, 8'h3F, 8'h44, 8'h40, 8'h20};
      "u":     return {8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C};
      "v":     return {8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C};
      "w":     return {8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C};
      "x":     return {8'h44, 8'h28, 8'h10, 8'h28, 8'h44};
      "y":     return {8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C};
      "z":     return {8'h44, 8'h64, 8'h54, 8'h4C, 8'h44};
      "0":     return {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      "1":     return {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      "2":     return {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      "3":     return {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      "4":     return {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      "5":     return {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      "6":     return {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      "7":     return {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      "8":     return {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      "9":     return {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      ":":     return {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      ".":     return {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      "!":     return {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
      "-":     return {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      ">":     return {8'h00, 8'h41, 8'h22, 8'h14, 8'h08};
      default: return '0;
    endcase
  endfunction

  function automatic void plot_nibble(input int x, input int y, input logic [3:0] shade);
    int idx;
    if (x >= SCR_W || y >= SCR_H) return;
    idx = y * ROW_BYTES + x / 2;
    if (x % 2 == 0) frame_copy[idx] = (frame_copy[idx] & NIB_LO_MASK) | {shade, 4'h0};
    else frame_copy[idx] = (frame_copy[idx] & NIB_HI_MASK) | {4'h0, shade};
  endfunction

  function automatic void plot_glyph(input logic [7:0] x, input logic [7:0] y,
                                     input logic [7:0] code, input logic [3:0] scale,
                                     input logic [3:0] shade);
    logic [39:0] bits;
    logic [7:0]  column;
    if (code >= 8'd128) return;
    bits = font_bits(code);
    for (int col = 0; col < GLYPH_COLS; col++) begin
      column = bits[39 - 8 * col -: 8];
      for (int row = 0; row < GLYPH_ROWS; row++) begin
        if (column[row]) begin
          for (int dx = 0; dx < scale; dx++) begin
            for (int dy = 0; dy < scale; dy++) begin
              plot_nibble((x + col * scale + dx) % 256, (y + row * scale + dy) % 256, shade);
            end
          end
        end
      end
    end
  endfunction

  // update the frame copy and queue the row words a command will return
  function automatic void apply_word(input gfb_op_t op, input logic [7:0] x,
                                     input logic [7:0] y, input logic [3:0] shade,
                                     input logic [7:0] code, input logic [3:0] scale);
    row_word_t w;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < STORE_BYTES; i++) frame_copy[i] = {shade, shade};
      end
      OP_PIXEL: plot_nibble(x, y, shade);
      OP_GLYPH: plot_glyph(x, y, code, scale, shade);
      default: begin
        if (y < SCR_H) begin
          for (int i = 0; i < ROW_WORDS; i++) begin
            w.pair = frame_copy[y * ROW_BYTES + i];
            w.last = (i == ROW_WORDS - 1);
            pending_words.push_back(w);
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin : check_words
    row_word_t want;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        flag_error($sformatf("unexpected word pixel_pair %02h last_byte %0b",
                             out_pixel_pair, out_last_byte));
      end else begin
        want = pending_words.pop_front();
        if (out_pixel_pair !== want.pair) begin
          flag_error($sformatf("pixel_pair exp %02h got %02h", want.pair, out_pixel_pair));
        end
        if (out_last_byte !== want.last) begin
          flag_error($sformatf("last_byte exp %0b got %0b", want.last, out_last_byte));
        end
      end
    end
  end

  task automatic send_word(input gfb_op_t op, input logic [7:0] x, input logic [7:0] y,
                           input logic [3:0] shade, input logic [7:0] code,
                           input logic [3:0] scale);
    @(negedge clk);
    in_op        = op;
    in_x_coord   = x;
    in_y_coord   = y;
    in_shade     = shade;
    in_char_code = code;
    in_scale     = scale;
    start        = 1'b1;
    do begin
      @(posedge clk);
    end while (busy);
    apply_word(op, x, y, shade, code, scale);
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_words.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic test_reset_state();
    send_word(OP_READ_ROW, 8'd0, 8'd0, 4'h0, 8'd0, 4'h0);
    send_word(OP_READ_ROW, 8'd255, 8'(SCR_H - 1), 4'hF, 8'd255, 4'hF);
    wait_drain();
  endtask

  task automatic test_clear();
    send_word(OP_CLEAR, 8'd0, 8'd0, 4'hF, 8'd0, 4'h0);
    send_word(OP_READ_ROW, 8'd0, 8'(SCR_H - 1), 4'h0, 8'd0, 4'h0);
    wait_drain();
  endtask

  task automatic test_pixels();
    send_word(OP_PIXEL, 8'd0, 8'd0, 4'h0, 8'd0, 4'h0);
    send_word(OP_PIXEL, 8'd1, 8'd0, 4'h5, 8'd0, 4'h0);
    send_word(OP_PIXEL, 8'(SCR_W - 1), 8'(SCR_H - 1), 4'h0, 8'd0, 4'h0);
    // off the screen, must be ignored
    send_word(OP_PIXEL, 8'(SCR_W), 8'd0, 4'h3, 8'd0, 4'h0);
    send_word(OP_PIXEL, 8'd0, 8'(SCR_H), 4'h3, 8'd0, 4'h0);
    send_word(OP_PIXEL, 8'd255, 8'd255, 4'h9, 8'd0, 4'h0);
    send_word(OP_READ_ROW, 8'd0, 8'd0, 4'h0, 8'd0, 4'h0);
    send_word(OP_READ_ROW, 8'd0, 8'(SCR_H - 1), 4'h0, 8'd0, 4'h0);
    wait_drain();
  endtask

  task automatic test_glyphs();
    send_word(OP_CLEAR, 8'd0, 8'd0, 4'h0, 8'd0, 4'h0);
    send_word(OP_GLYPH, 8'd0, 8'd8, 4'h7, "a", 4'd1);
    // wraps past column 255 back onto the left edge
    send_word(OP_GLYPH, 8'd250, 8'd16, 4'hF, "0", 4'd2);
    // wraps past row 255 back onto the top rows
    send_word(OP_GLYPH, 8'd40, 8'd250, 4'h3, "!", 4'd15);
    // codes at or above 128, zero scale and empty codes draw nothing
    send_word(OP_GLYPH, 8'd0, 8'd0, 4'hC, 8'd200, 4'd1);
    send_word(OP_GLYPH, 8'd0, 8'd0, 4'hC, 8'd255, 4'd3);
    send_word(OP_GLYPH, 8'd0, 8'd0, 4'hC, "8", 4'd0);
    send_word(OP_GLYPH, 8'd0, 8'd0, 4'hC, "A", 4'd4);
    send_word(OP_GLYPH, 8'd0, 8'd0, 4'hC, 8'd127, 4'd1);
    send_word(OP_READ_ROW, 8'd0, 8'd8, 4'h0, 8'd0, 4'h0);
    send_word(OP_READ_ROW, 8'd0, 8'd16, 4'h0, 8'd0, 4'h0);
    send_word(OP_READ_ROW, 8'd0, 8'd20, 4'h0, 8'd0, 4'h0);
    send_word(OP_READ_ROW, 8'd0, 8'd0, 4'h0, 8'd0, 4'h0);
    wait_drain();
  endtask

  task automatic test_read_off_screen();
    send_word(OP_READ_ROW, 8'd0, 8'(SCR_H), 4'h0, 8'd0, 4'h0);
    send_word(OP_READ_ROW, 8'd255, 8'd255, 4'hF, 8'd255, 4'hF);
    send_word(OP_READ_ROW, 8'd0, 8'd1, 4'h0, 8'd0, 4'h0);
    wait_drain();
  endtask

  task automatic test_random();
    int         burst_left;
    int         pick;
    gfb_op_t    op;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] code;
    logic [3:0] shade;
    logic [3:0] scale;
    burst_left = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) wait_drain();
      if (burst_left == 0) begin
        idle_cycles(($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5));
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      pick  = $urandom_range(0, 99);
      shade = 4'($urandom_range(0, 15));
      code  = 8'($urandom_range(0, 255));
      scale = 4'($urandom_range(0, 15));
      x = 8'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, SCR_W - 1));
      y = 8'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, SCR_H - 1));
      if (pick < 2) begin
        op = OP_CLEAR;
      end else if (pick < 42) begin
        op = OP_PIXEL;
        last_row = y;
      end else if (pick < 67) begin
        op = OP_GLYPH;
        if (pick < 63) code = glyph_set[$urandom_range(0, glyph_set.len() - 1)];
        // mostly small glyphs, large scales are slow
        scale = 4'(($urandom_range(0, 11) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(1, 3));
        last_row = 8'(y + $urandom_range(0, 7 * scale));
      end else begin
        op = OP_READ_ROW;
        if (pick < 85) y = last_row;
      end
      send_word(op, x, y, shade, code, scale);
    end
  endtask

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) frame_copy[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_clear();
    test_pixels();
    test_glyphs();
    test_read_off_screen();
    test_random();
    wait_drain();
    repeat (20) @(negedge clk);
    if (pending_words.size() != 0) begin
      flag_error($sformatf("%0d row words never arrived", pending_words.size()));
    end
    if (mismatch_count == 0) begin
      $display("** gray4_framebuffer_glyph_renderer: PASSED **");
    end else begin
      $display("** gray4_framebuffer_glyph_renderer: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/gfb_pkg.sv
src/gfb_ctrl.sv
src/gfb_datapath.sv
src/gray4_framebuffer_glyph_renderer.sv
verif/tb.sv
